@@ rtl/msb_pkg.sv @@
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types, codes and helpers of the masked palette sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package msb_pkg;

    // store geometry
    localparam int PALETTE_DEPTH = 16;
    localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);
    localparam int TEXEL_BYTES   = 2048;
    localparam int TEXEL_AW      = $clog2(TEXEL_BYTES);

    // write limit per source pixel
    localparam int MAX_WRITES = 64;
    localparam int WCOUNT_W   = $clog2(MAX_WRITES);

    // input command codes
    typedef enum logic [2:0] {
        CMD_PALETTE     = 3'd0,
        CMD_TEXEL       = 3'd1,
        CMD_FRAME_START = 3'd2,
        CMD_PIXEL       = 3'd3,
        CMD_FRAME_END   = 3'd4
    } cmd_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_FRAME_BAD = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SCALE      = 3'd0,
        REG_CLIP_LEFT  = 3'd1,
        REG_CLIP_TOP   = 3'd2,
        REG_CLIP_RIGHT = 3'd3,
        REG_CLIP_BOT   = 3'd4,
        REG_VIEW_X     = 3'd5,
        REG_VIEW_Y     = 3'd6,
        REG_PITCH      = 3'd7
    } cfg_idx_t;

    // rgb565 red/blue field swap applied on palette load
    function automatic logic [15:0] swap_red_blue(input logic [15:0] c);
        return {c[4:0], c[10:5], c[15:11]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/msb_ram.sv @@
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/masked_palette_sprite_blitter.sv @@
// ----------------------------------------------------------------------------
// masked_palette_sprite_blitter
// Scaled, clipped 4-bit palette sprite blitter emitting framebuffer writes.
// ----------------------------------------------------------------------------
// Loads, frame start and ignored commands are handled in the idle state. A
// frame end gives one status word. An opaque source pixel goes through the
// texel memory read, palette memory read, rectangle clip and row address
// multiply before its first write, and then takes one cycle per framebuffer
// write, up to 64, while the result side keeps up; the sequencer holds one
// item at a time. A transparent pixel, a pixel after failure or an overrun
// writes nothing. Configuration may be written only while the block is idle;
// the next input word is taken while the last result word still waits in the
// output register.
`default_nettype none

module masked_palette_sprite_blitter
    import msb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data,
    // command input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_command,
    input  wire logic [10:0]        s_index,
    input  wire logic [15:0]        s_value,
    input  wire logic [7:0]         s_source_x,
    input  wire logic [7:0]         s_source_y,
    input  wire logic               s_opaque,
    input  wire logic signed [11:0] s_anchor_x,
    input  wire logic signed [11:0] s_anchor_y,
    input  wire logic [12:0]        s_active_count,
    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_kind,
    output logic [9:0]              m_pixel_x,
    output logic [9:0]              m_pixel_y,
    output logic [21:0]             m_address,
    output logic [15:0]             m_color,
    output logic                    m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RECT,
        ST_BASE,
        ST_EMIT,
        ST_END
    } state_t;

    // configuration registers
    logic [11:0] scale_reg;
    logic [9:0]  clip_left_reg;
    logic [9:0]  clip_top_reg;
    logic [9:0]  clip_right_reg;
    logic [9:0]  clip_bot_reg;
    logic [9:0]  view_x_reg;
    logic [9:0]  view_y_reg;
    logic [11:0] pitch_reg;

    // control state
    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [12:0]        cursor_reg, cursor_next;
    logic [12:0]        expected_reg, expected_next;
    logic signed [11:0] anchor_x_reg, anchor_x_next;
    logic signed [11:0] anchor_y_reg, anchor_y_next;
    logic               failed_reg, failed_next;

    // datapath registers
    logic                nib_sel_reg, nib_sel_next;
    logic [7:0]          sx_reg, sx_next;
    logic [7:0]          sy_reg, sy_next;
    logic [11:0]         px0_reg, px0_next;
    logic [12:0]         px1_reg, px1_next;
    logic [11:0]         py0_reg, py0_next;
    logic [12:0]         py1_reg, py1_next;
    logic [15:0]         color_reg, color_next;
    logic [9:0]          x0_reg, x0_next;
    logic [9:0]          x1_reg, x1_next;
    logic [9:0]          y0_reg, y0_next;
    logic [9:0]          y1_reg, y1_next;
    logic [9:0]          dx_reg, dx_next;
    logic [9:0]          dy_reg, dy_next;
    logic [21:0]         row_reg, row_next;
    logic [21:0]         addr_reg, addr_next;
    logic [WCOUNT_W-1:0] wcount_reg, wcount_next;

    // output payload registers
    logic [1:0]  kind_reg, kind_next;
    logic [9:0]  px_reg, px_next;
    logic [9:0]  py_reg, py_next;
    logic [21:0] oaddr_reg, oaddr_next;
    logic [15:0] ocolor_reg, ocolor_next;
    logic        last_reg, last_next;

    // memory ports
    logic                  pal_we, pal_re;
    logic [PALETTE_AW-1:0] pal_raddr;
    logic [15:0]           pal_rdata;
    logic                  tex_we, tex_re;
    logic [TEXEL_AW-1:0]   tex_raddr;
    logic [7:0]            tex_rdata;

    // geometry
    logic [19:0]        prod_x0, prod_y0;
    logic [20:0]        prod_x1, prod_y1;
    logic signed [13:0] rx0, rx1, ry0, ry1;
    logic signed [13:0] rx1_min, ry1_min;
    logic signed [13:0] cx0, cx1, cy0, cy1;
    logic               rect_empty;
    logic [10:0]        vy_sum;
    logic [22:0]        row_prod;
    logic               out_free;
    logic               col_end, row_end, write_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_kind    = kind_reg;
    assign m_pixel_x = px_reg;
    assign m_pixel_y = py_reg;
    assign m_address = oaddr_reg;
    assign m_color   = ocolor_reg;
    assign m_last    = last_reg;

    // palette memory, written red/blue swapped
    msb_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s_index[PALETTE_AW-1:0]),
        .wdata (swap_red_blue(s_value)),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // packed texel memory
    msb_ram #(
        .WIDTH (8),
        .DEPTH (TEXEL_BYTES)
    ) u_texel (
        .aclk  (aclk),
        .we    (tex_we),
        .waddr (s_index[TEXEL_AW-1:0]),
        .wdata (s_value[7:0]),
        .re    (tex_re),
        .raddr (tex_raddr),
        .rdata (tex_rdata)
    );

    // texel byte of the cursor, then the nibble it selects
    assign tex_raddr = TEXEL_AW'(cursor_reg >> 1);
    assign pal_raddr = nib_sel_reg ? tex_rdata[7:4] : tex_rdata[3:0];

    // scaled source edges
    assign prod_x0 = {12'd0, sx_reg} * {8'd0, scale_reg};
    assign prod_x1 = ({13'd0, sx_reg} + 21'd1) * {9'd0, scale_reg};
    assign prod_y0 = {12'd0, sy_reg} * {8'd0, scale_reg};
    assign prod_y1 = ({13'd0, sy_reg} + 21'd1) * {9'd0, scale_reg};

    // screen rectangle, at least one pixel, then clipped
    always_comb begin
        rx0 = $signed({{2{anchor_x_reg[11]}}, anchor_x_reg}) + $signed({2'b00, px0_reg});
        rx1 = $signed({{2{anchor_x_reg[11]}}, anchor_x_reg}) + $signed({1'b0, px1_reg});
        ry0 = $signed({{2{anchor_y_reg[11]}}, anchor_y_reg}) + $signed({2'b00, py0_reg});
        ry1 = $signed({{2{anchor_y_reg[11]}}, anchor_y_reg}) + $signed({1'b0, py1_reg});
        rx1_min = (rx1 <= rx0) ? rx0 + 14'sd1 : rx1;
        ry1_min = (ry1 <= ry0) ? ry0 + 14'sd1 : ry1;
        cx0 = (rx0 < $signed({4'd0, clip_left_reg})) ? $signed({4'd0, clip_left_reg}) : rx0;
        cx1 = (rx1_min > $signed({4'd0, clip_right_reg})) ?
              $signed({4'd0, clip_right_reg}) : rx1_min;
        cy0 = (ry0 < $signed({4'd0, clip_top_reg})) ? $signed({4'd0, clip_top_reg}) : ry0;
        cy1 = (ry1_min > $signed({4'd0, clip_bot_reg})) ?
              $signed({4'd0, clip_bot_reg}) : ry1_min;
        rect_empty = (cx0 >= cx1) || (cy0 >= cy1);
    end

    // first row address of the rectangle
    assign vy_sum   = {1'b0, view_y_reg} + {1'b0, y0_reg};
    assign row_prod = {12'd0, vy_sum} * {11'd0, pitch_reg};

    // write scan position
    assign out_free   = !m_valid_reg || m_ready;
    assign col_end    = ({1'b0, dx_reg} + 11'd1) == {1'b0, x1_reg};
    assign row_end    = ({1'b0, dy_reg} + 11'd1) == {1'b0, y1_reg};
    assign write_last = (col_end && row_end) ||
                        (wcount_reg == WCOUNT_W'(MAX_WRITES - 1));

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        cursor_next   = cursor_reg;
        expected_next = expected_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        failed_next   = failed_reg;
        nib_sel_next  = nib_sel_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        px0_next      = px0_reg;
        px1_next      = px1_reg;
        py0_next      = py0_reg;
        py1_next      = py1_reg;
        color_next    = color_reg;
        x0_next       = x0_reg;
        x1_next       = x1_reg;
        y0_next       = y0_reg;
        y1_next       = y1_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        row_next      = row_reg;
        addr_next     = addr_reg;
        wcount_next   = wcount_reg;
        kind_next     = kind_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        oaddr_next    = oaddr_reg;
        ocolor_next   = ocolor_reg;
        last_next     = last_reg;
        pal_we        = 1'b0;
        pal_re        = 1'b0;
        tex_we        = 1'b0;
        tex_re        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        CMD_PALETTE: begin
                            pal_we = (s_index[10:PALETTE_AW] == '0);
                        end
                        CMD_TEXEL: begin
                            tex_we = (32'(s_index) < TEXEL_BYTES);
                        end
                        CMD_FRAME_START: begin
                            anchor_x_next = s_anchor_x;
                            anchor_y_next = s_anchor_y;
                            expected_next = s_active_count;
                            cursor_next   = '0;
                            failed_next   = 1'b0;
                        end
                        CMD_PIXEL: begin
                            if (s_opaque && !failed_reg) begin
                                if (cursor_reg >= expected_reg) begin
                                    failed_next = 1'b1;
                                end else begin
                                    tex_re       = 1'b1;
                                    nib_sel_next = cursor_reg[0];
                                    cursor_next  = cursor_reg + 13'd1;
                                    sx_next      = s_source_x;
                                    sy_next      = s_source_y;
                                    state_next   = ST_LOOK;
                                end
                            end
                        end
                        CMD_FRAME_END: begin
                            state_next = ST_END;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                pal_re     = 1'b1;
                px0_next   = prod_x0[19:8];
                px1_next   = prod_x1[20:8];
                py0_next   = prod_y0[19:8];
                py1_next   = prod_y1[20:8];
                state_next = ST_RECT;
            end
            ST_RECT: begin
                color_next = pal_rdata;
                x0_next    = cx0[9:0];
                x1_next    = cx1[9:0];
                y0_next    = cy0[9:0];
                y1_next    = cy1[9:0];
                state_next = rect_empty ? ST_IDLE : ST_BASE;
            end
            ST_BASE: begin
                row_next    = row_prod[21:0] + {12'd0, view_x_reg};
                addr_next   = row_prod[21:0] + {12'd0, view_x_reg} + {12'd0, x0_reg};
                dx_next     = x0_reg;
                dy_next     = y0_reg;
                wcount_next = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_PIXEL;
                    px_next      = dx_reg;
                    py_next      = dy_reg;
                    oaddr_next   = addr_reg;
                    ocolor_next  = color_reg;
                    last_next    = write_last;
                    wcount_next  = wcount_reg + WCOUNT_W'(1);
                    if (write_last) begin
                        state_next = ST_IDLE;
                    end else if (col_end) begin
                        dx_next   = x0_reg;
                        dy_next   = dy_reg + 10'd1;
                        row_next  = row_reg + {10'd0, pitch_reg};
                        addr_next = row_reg + {10'd0, pitch_reg} + {12'd0, x0_reg};
                    end else begin
                        dx_next   = dx_reg + 10'd1;
                        addr_next = addr_reg + 22'd1;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = (!failed_reg && cursor_reg == expected_reg) ?
                                   KIND_FRAME_OK : KIND_FRAME_BAD;
                    px_next      = '0;
                    py_next      = '0;
                    oaddr_next   = '0;
                    ocolor_next  = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            cursor_reg   <= '0;
            expected_reg <= '0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            failed_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            cursor_reg   <= cursor_next;
            expected_reg <= expected_next;
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            failed_reg   <= failed_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge aclk) begin
        nib_sel_reg <= nib_sel_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        px0_reg     <= px0_next;
        px1_reg     <= px1_next;
        py0_reg     <= py0_next;
        py1_reg     <= py1_next;
        color_reg   <= color_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        row_reg     <= row_next;
        addr_reg    <= addr_next;
        wcount_reg  <= wcount_next;
        kind_reg    <= kind_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        oaddr_reg   <= oaddr_next;
        ocolor_reg  <= ocolor_next;
        last_reg    <= last_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= 12'd321;
            clip_left_reg  <= 10'd0;
            clip_top_reg   <= 10'd0;
            clip_right_reg <= 10'd160;
            clip_bot_reg   <= 10'd80;
            view_x_reg     <= 10'd0;
            view_y_reg     <= 10'd20;
            pitch_reg      <= 12'd160;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SCALE:      scale_reg      <= cfg_data;
                REG_CLIP_LEFT:  clip_left_reg  <= cfg_data[9:0];
                REG_CLIP_TOP:   clip_top_reg   <= cfg_data[9:0];
                REG_CLIP_RIGHT: clip_right_reg <= cfg_data[9:0];
                REG_CLIP_BOT:   clip_bot_reg   <= cfg_data[9:0];
                REG_VIEW_X:     view_x_reg     <= cfg_data[9:0];
                REG_VIEW_Y:     view_y_reg     <= cfg_data[9:0];
                REG_PITCH:      pitch_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the cursor never passes the expected count
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= expected_reg)
        else $error("pixel cursor passed expected count");

    // a failed frame consumes no texels until the next frame start
    a_failed_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg && !(s_valid && s_ready && s_command == CMD_FRAME_START)
        |=> $stable(cursor_reg))
        else $error("cursor moved in a failed frame");

    // a frame status word always closes its command
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PIXEL |-> m_last)
        else $error("frame status word without last");

    // a write word is only produced from the scan state
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_kind == KIND_PIXEL |-> $past(state_reg) == ST_EMIT)
        else $error("pixel word outside of scan");
`endif

endmodule

`default_nettype wire

@@ test/masked_palette_sprite_blitter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_palette_sprite_blitter_test
// Self-checking bench for the scaled, clipped palette sprite blitter.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver. Every accepted command goes
// through a local copy of the blitter's behavior, which queues the
// framebuffer and status words it should cause. A clocked monitor pops that
// queue and compares each delivered word field by field. The run covers a
// short directed set, an over-range scale, high and low register settings and
// several random view settings, with random stalls on both sides and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------

module masked_palette_sprite_blitter_test;
    import msb_pkg::*;

    localparam int          DRAIN_CYCLES   = 100;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          PRELOAD_BYTES  = 16;
    localparam int          OPAQUE_CAP     = 2 * PRELOAD_BYTES;
    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0]         command;
        logic [10:0]        index;
        logic [15:0]        value;
        logic [7:0]         sx;
        logic [7:0]         sy;
        logic               opaque;
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic [12:0]        count;
    } blit_cmd_t;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [21:0] addr;
        logic [15:0] color;
        logic        last;
    } fb_word_t;

    // clock, reset and block ports
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [11:0]        cfg_data  = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = '0;
    logic [10:0]        s_index   = '0;
    logic [15:0]        s_value   = '0;
    logic [7:0]         s_source_x = '0;
    logic [7:0]         s_source_y = '0;
    logic               s_opaque  = 1'b0;
    logic signed [11:0] s_anchor_x = '0;
    logic signed [11:0] s_anchor_y = '0;
    logic [12:0]        s_active_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_kind;
    logic [9:0]         m_pixel_x;
    logic [9:0]         m_pixel_y;
    logic [21:0]        m_address;
    logic [15:0]        m_color;
    logic               m_last;

    masked_palette_sprite_blitter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_index        (s_index),
        .s_value        (s_value),
        .s_source_x     (s_source_x),
        .s_source_y     (s_source_y),
        .s_opaque       (s_opaque),
        .s_anchor_x     (s_anchor_x),
        .s_anchor_y     (s_anchor_y),
        .s_active_count (s_active_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_address      (m_address),
        .m_color        (m_color),
        .m_last         (m_last)
    );

    // queues between stimulus, driver, predictor and monitor
    blit_cmd_t cmd_q[$];
    fb_word_t  due_q[$];
    blit_cmd_t on_port;
    int        bad_words     = 0;
    int        opaque_sent   = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_req      = 1'b0;

    // shadow of the blitter state
    logic [15:0] palette_mem [PALETTE_DEPTH];
    logic [7:0]  texel_mem   [TEXEL_BYTES];
    logic [12:0] cursor     = '0;
    logic [12:0] want_count = '0;
    int          anc_x      = 0;
    int          anc_y      = 0;
    bit          failed     = 1'b0;

    // shadow of the view registers, reset values
    int scale_r  = 321;
    int clip_l   = 0;
    int clip_t   = 0;
    int clip_r   = 160;
    int clip_b   = 80;
    int view_x_r = 0;
    int view_y_r = 20;
    int pitch_r  = 160;

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register write side of the shadow
    function automatic void apply_reg(input cfg_idx_t idx, input logic [11:0] d);
        case (idx)
            REG_SCALE:      scale_r  = d;
            REG_CLIP_LEFT:  clip_l   = d[9:0];
            REG_CLIP_TOP:   clip_t   = d[9:0];
            REG_CLIP_RIGHT: clip_r   = d[9:0];
            REG_CLIP_BOT:   clip_b   = d[9:0];
            REG_VIEW_X:     view_x_r = d[9:0];
            REG_VIEW_Y:     view_y_r = d[9:0];
            REG_PITCH:      pitch_r  = d;
            default: ;
        endcase
    endfunction

    // expected words for one accepted command
    function automatic void render_item(input blit_cmd_t c);
        int x0, x1, y0, y1, dx, dy, total, n, sxi, syi;
        logic [7:0]  tex_byte;
        logic [3:0]  nib;
        logic [15:0] col;
        fb_word_t    w;
        case (c.command)
            CMD_PALETTE: begin
                // red and blue fields trade places on load
                if (c.index < PALETTE_DEPTH)
                    palette_mem[c.index[3:0]] = {c.value[4:0], c.value[10:5], c.value[15:11]};
            end
            CMD_TEXEL: begin
                if (c.index < TEXEL_BYTES)
                    texel_mem[c.index] = c.value[7:0];
            end
            CMD_FRAME_START: begin
                anc_x      = c.ax;
                anc_y      = c.ay;
                want_count = c.count;
                cursor     = '0;
                failed     = 1'b0;
            end
            CMD_FRAME_END: begin
                w.kind  = (!failed && cursor == want_count) ? KIND_FRAME_OK : KIND_FRAME_BAD;
                w.px    = '0;
                w.py    = '0;
                w.addr  = '0;
                w.color = '0;
                w.last  = 1'b1;
                due_q.push_back(w);
            end
            CMD_PIXEL: begin
                if (c.opaque && !failed) begin
                    if (cursor >= want_count) begin
                        // overrun: sticky failure, nothing drawn
                        failed = 1'b1;
                    end else begin
                        tex_byte = texel_mem[cursor[11:1]];
                        nib      = cursor[0] ? tex_byte[7:4] : tex_byte[3:0];
                        col      = palette_mem[nib];
                        cursor   = cursor + 13'd1;
                        // scaled rectangle, at least one pixel each way
                        sxi = c.sx;
                        syi = c.sy;
                        x0 = anc_x + ((sxi * scale_r) >> 8);
                        x1 = anc_x + (((sxi + 1) * scale_r) >> 8);
                        y0 = anc_y + ((syi * scale_r) >> 8);
                        y1 = anc_y + (((syi + 1) * scale_r) >> 8);
                        if (x1 <= x0) x1 = x0 + 1;
                        if (y1 <= y0) y1 = y0 + 1;
                        if (x0 < clip_l) x0 = clip_l;
                        if (x1 > clip_r) x1 = clip_r;
                        if (y0 < clip_t) y0 = clip_t;
                        if (y1 > clip_b) y1 = clip_b;
                        if (x0 < x1 && y0 < y1) begin
                            total = (x1 - x0) * (y1 - y0);
                            if (total > MAX_WRITES) total = MAX_WRITES;
                            n = 0;
                            for (dy = y0; dy < y1 && n < total; dy++) begin
                                for (dx = x0; dx < x1 && n < total; dx++) begin
                                    w.kind  = KIND_PIXEL;
                                    w.px    = dx[9:0];
                                    w.py    = dy[9:0];
                                    w.addr  = 22'((view_y_r + dy) * pitch_r + view_x_r + dx);
                                    w.color = col;
                                    w.last  = (n == total - 1);
                                    due_q.push_back(w);
                                    n++;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                render_item(on_port);
            if (!s_valid || s_ready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_port = cmd_q.pop_front();
                    s_command      <= on_port.command;
                    s_index        <= on_port.index;
                    s_value        <= on_port.value;
                    s_source_x     <= on_port.sx;
                    s_source_y     <= on_port.sy;
                    s_opaque       <= on_port.opaque;
                    s_anchor_x     <= on_port.ax;
                    s_anchor_y     <= on_port.ay;
                    s_active_count <= on_port.count;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and the long hold-off
    int hold_left = 0;
    bit hold_seen = 1'b0;
    always @(posedge aclk) begin
        fb_word_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: word with nothing expected: %s",
                                 $time, $sformatf("kind=%0d x=%0d y=%0d addr=%0h",
                                 m_kind, m_pixel_x, m_pixel_y, m_address));
                end else begin
                    e = due_q.pop_front();
                    if (m_kind !== e.kind || m_pixel_x !== e.px || m_pixel_y !== e.py ||
                        m_address !== e.addr || m_color !== e.color || m_last !== e.last) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("%0t: word mismatch, expected %s", $time,
                                     $sformatf("kind=%0d x=%0d y=%0d addr=%0h color=%0h last=%0d",
                                     e.kind, e.px, e.py, e.addr, e.color, e.last));
                            $display("%0t:                  got %s", $time,
                                     $sformatf("kind=%0d x=%0d y=%0d addr=%0h color=%0h last=%0d",
                                     m_kind, m_pixel_x, m_pixel_y, m_address, m_color,
                                     m_last));
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any accepted word
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("masked_palette_sprite_blitter_test NOT OK");
            $finish;
        end
    end

    // stimulus helpers
    function automatic logic [11:0] clamp12(input int v);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return 12'(v);
    endfunction

    function automatic blit_cmd_t rand_fields();
        blit_cmd_t c;
        c.command = 3'($urandom_range(7));
        c.index   = 11'($urandom);
        c.value   = 16'($urandom);
        c.sx      = 8'($urandom);
        c.sy      = 8'($urandom);
        c.opaque  = 1'($urandom);
        c.ax      = 12'($urandom);
        c.ay      = 12'($urandom);
        c.count   = 13'($urandom_range(4096));
        return c;
    endfunction

    // opaque pixels per frame stay within what the preloaded texels cover
    function automatic void push_cmd(input blit_cmd_t c);
        if (c.command == CMD_FRAME_START)
            opaque_sent = 0;
        if (c.command == CMD_PIXEL && c.opaque) begin
            if (opaque_sent >= OPAQUE_CAP) c.opaque = 1'b0;
            else opaque_sent++;
        end
        cmd_q.push_back(c);
    endfunction

    function automatic void queue_op(input logic [2:0] cmd, input int idx, input int val);
        blit_cmd_t c;
        c = rand_fields();
        c.command = cmd;
        c.index   = 11'(idx);
        c.value   = 16'(val);
        push_cmd(c);
    endfunction

    function automatic void queue_start(input int ax, input int ay, input int cnt);
        blit_cmd_t c;
        c = rand_fields();
        c.command = CMD_FRAME_START;
        c.ax      = clamp12(ax);
        c.ay      = clamp12(ay);
        c.count   = 13'(cnt);
        push_cmd(c);
    endfunction

    function automatic void queue_pixel(input int sx, input int sy, input bit op);
        blit_cmd_t c;
        c = rand_fields();
        c.command = CMD_PIXEL;
        c.sx      = 8'(sx);
        c.sy      = 8'(sy);
        c.opaque  = op;
        push_cmd(c);
    endfunction

    // one sprite frame: start, column-major pixels with an occasional load, end
    function automatic int queue_frame();
        bit ops [16];
        int w, h, sx0, sy0, planned, cnt, lo, hi, ax, ay, k, col_i, row_i, n;
        w   = $urandom_range(4, 1);
        h   = $urandom_range(4, 1);
        sx0 = ($urandom_range(4) == 0) ? $urandom_range(252) : 0;
        sy0 = ($urandom_range(4) == 0) ? $urandom_range(252) : 0;
        planned = 0;
        for (k = 0; k < w * h; k++) begin
            ops[k] = ($urandom_range(4) != 0);
            planned += ops[k];
        end
        // mostly the right count, sometimes one short, one over or random
        k = $urandom_range(19);
        if (k < 3 && planned > 0) cnt = planned - 1;
        else if (k < 5) cnt = planned + 1;
        else if (k == 5) cnt = $urandom_range(4096);
        else cnt = planned;
        // anchor near the clip window, now and then anywhere
        lo = ((clip_l < clip_r) ? clip_l : clip_r) - 12;
        hi = ((clip_l < clip_r) ? clip_r : clip_l) + 2;
        ax = lo + $urandom_range(hi - lo) - ((sx0 * scale_r) >> 8);
        lo = ((clip_t < clip_b) ? clip_t : clip_b) - 12;
        hi = ((clip_t < clip_b) ? clip_b : clip_t) + 2;
        ay = lo + $urandom_range(hi - lo) - ((sy0 * scale_r) >> 8);
        if ($urandom_range(9) == 0) begin
            ax = $urandom_range(4095) - 2048;
            ay = $urandom_range(4095) - 2048;
        end
        queue_start(ax, ay, cnt);
        n = 2 + w * h;
        for (col_i = 0; col_i < w; col_i++) begin
            for (row_i = 0; row_i < h; row_i++) begin
                if ($urandom_range(15) == 0) begin
                    if ($urandom_range(1) != 0)
                        queue_op(CMD_TEXEL, $urandom_range(2047), $urandom);
                    else
                        queue_op(CMD_PALETTE, $urandom_range(31), $urandom);
                    n++;
                end
                queue_pixel(sx0 + col_i, sy0 + row_i, ops[col_i * h + row_i]);
            end
        end
        queue_op(CMD_FRAME_END, $urandom_range(2047), $urandom);
        return n;
    endfunction

    // mostly whole frames, the rest single random commands
    function automatic void random_phase(input int target);
        int n;
        blit_cmd_t c;
        n = 0;
        while (n < target) begin
            if ($urandom_range(99) < 85) begin
                n += queue_frame();
            end else begin
                c = rand_fields();
                if (c.command == CMD_PALETTE) c.index = 11'($urandom_range(31));
                push_cmd(c);
                n++;
            end
        end
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 12'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_reg(idx, 12'(val));
    endtask

    task automatic program_view(input int sc, input int cl, input int ct, input int cr,
                                input int cb, input int vx, input int vy, input int pitch);
        write_reg(REG_SCALE, sc);
        write_reg(REG_CLIP_LEFT, cl);
        write_reg(REG_CLIP_TOP, ct);
        write_reg(REG_CLIP_RIGHT, cr);
        write_reg(REG_CLIP_BOT, cb);
        write_reg(REG_VIEW_X, vx);
        write_reg(REG_VIEW_Y, vy);
        write_reg(REG_PITCH, pitch);
    endtask

    task automatic random_view();
        int sc, cl, ct, k;
        k = $urandom_range(19);
        if (k < 14) sc = $urandom_range(512, 64);
        else if (k < 17) sc = $urandom_range(63, 1);
        else sc = $urandom_range(2048, 513);
        cl = $urandom_range(300);
        ct = $urandom_range(300);
        program_view(sc, cl, ct, cl + $urandom_range(240), ct + $urandom_range(240),
                     $urandom_range(1023), $urandom_range(1023), $urandom_range(2048, 1));
    endtask

    // wait until every command is in and every word is out, then let it settle
    task automatic settle();
        do @(negedge aclk); while (cmd_q.size() != 0 || s_valid || due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // run sequence
    initial begin
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 11;
        recv_idle_pct = 77;

        // fill the palette and the texels that frames will read
        for (k = 0; k < PALETTE_DEPTH; k++) queue_op(CMD_PALETTE, k, $urandom);
        for (k = 0; k < PRELOAD_BYTES; k++) queue_op(CMD_TEXEL, k, $urandom);

        // directed set at reset view settings
        queue_pixel(0, 0, 1'b1);                    // overrun before any frame
        queue_op(CMD_FRAME_END, 0, 0);
        queue_start(0, 0, 3);
        queue_pixel(0, 0, 1'b1);
        queue_pixel(0, 1, 1'b0);                    // transparent
        queue_pixel(0, 1, 1'b1);
        queue_pixel(255, 255, 1'b1);                // fully clipped, texel consumed
        queue_op(CMD_FRAME_END, 2047, 16'hffff);
        queue_pixel(1, 0, 1'b1);                    // overrun
        queue_pixel(1, 1, 1'b1);                    // ignored after failure
        queue_op(CMD_FRAME_END, 0, 0);
        queue_op(CMD_PALETTE, 31, 16'hffff);        // out of range, ignored
        queue_op(CMD_PALETTE, 15, 16'hffff);
        queue_op(CMD_PALETTE, 0, 16'h0000);
        queue_op(CMD_TEXEL, 2047, 16'hffff);
        queue_op(CMD_SPARE_FIRST, 0, 0);
        queue_op(CMD_SPARE_LAST, 2047, 16'hffff);
        queue_start(-2048, -2048, 4096);
        queue_pixel(255, 255, 1'b1);
        queue_op(CMD_FRAME_END, 0, 0);
        queue_start(2047, 2047, 0);
        queue_op(CMD_FRAME_END, 0, 0);
        queue_pixel(0, 0, 1'b1);
        queue_start(-3, -2, 2);                     // clipped away on the left and top
        queue_pixel(0, 0, 1'b1);
        queue_pixel(0, 1, 1'b1);
        queue_op(CMD_FRAME_END, 0, 0);
        settle();

        // scale past its range: rectangle larger than the write limit
        write_reg(REG_SCALE, 4095);
        queue_start(0, 0, 2);
        queue_pixel(0, 0, 1'b1);
        queue_pixel(0, 1, 1'b1);
        queue_op(CMD_FRAME_END, 0, 0);
        settle();

        // high values in every register
        program_view(2048, 1000, 1000, 1023, 1023, 1023, 1023, 2048);
        random_phase(30);
        settle();

        // low scale, pitch, clip start and view offset
        program_view(1, 0, 0, 1023, 1023, 0, 0, 1);
        random_phase(55);
        settle();

        send_idle_pct = 77;
        recv_idle_pct = 11;
        random_view();
        random_phase(60);
        settle();
        random_view();
        random_phase(60);
        settle();

        // no idling; long receiver hold-off backs the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_view();
        hold_req = !hold_req;
        random_phase(55);
        settle();
        random_view();
        random_phase(55);
        settle();

        if (bad_words == 0 && due_q.size() == 0)
            $display("masked_palette_sprite_blitter_test OK");
        else
            $display("masked_palette_sprite_blitter_test NOT OK");
        $finish;
    end

endmodule
